[hw/rtl/cdf_pkg.sv]
// cdf_pkg: payload structs, sequencer states, unit request types and fixed-point
// constants for the critically damped follower. Depends on nothing.
package cdf_pkg;

    typedef struct packed {
        logic signed [31:0] current_value;
        logic signed [31:0] target_value;
        logic        [15:0] frame_time;
    } t_in;

    typedef struct packed {
        logic signed [31:0] new_value;
        logic signed [31:0] new_velocity;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE, S_OMEGA, S_ANGLE, S_X, S_X2, S_X3, S_C1, S_C2,
        S_EF, S_T1, S_T2, S_T3, S_V, S_VAL, S_WB
    } t_state;

    typedef struct packed {
        logic        start;
        logic [62:0] a;
        logic [33:0] b;
        logic        sh32;
    } t_mul_req;

    typedef struct packed {
        logic        done;
        logic [62:0] res;
    } t_mul_rsp;

    typedef struct packed {
        logic        start;
        logic [49:0] n;
        logic [49:0] d;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [49:0] q;
    } t_div_rsp;

    localparam logic CFG_SMOOTH_TIME = 1'b0;
    localparam logic CFG_ANGLE_MODE  = 1'b1;

    localparam logic [23:0] ST_RESET = 24'd6554;
    localparam logic [33:0] C048     = 34'd31457;
    localparam logic [33:0] C0235    = 34'd15401;
    localparam logic signed [63:0] PI_Q = 64'sd205887;
    localparam logic [18:0] TWO_PI_Q = 19'd411775;
    // floor(2^32 / TWO_PI_Q), quotient estimate is exact or one too high
    localparam logic [33:0] RECIP_2PI = 34'd10430;
    localparam logic [62:0] UCAP = 63'h4000_0000_0000_0000;
    localparam logic signed [63:0] SLIM = 64'sh2000_0000_0000_0000;
    localparam int DIV_STEPS = 50;

    function automatic logic signed [63:0] f_sclamp(input logic signed [63:0] v);
        if (v > SLIM) return SLIM;
        if (v < -SLIM) return -SLIM;
        return v;
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [62:0] f_uadd(input logic [62:0] a, input logic [62:0] b);
        logic [63:0] s;
        s = 64'(a) + 64'(b);
        return (s > 64'(UCAP)) ? UCAP : s[62:0];
    endfunction

endpackage

[hw/rtl/cdf_mul.sv]
// cdf_mul: shared unsigned multiplier, 63 x 17 bits per cycle over two digits,
// with round half up, scaling by 2^16 or 2^32 and saturation. Uses cdf_pkg.
module cdf_mul import cdf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);
    logic [62:0] r_a;
    logic [33:0] r_b;
    logic        r_sh;
    logic [96:0] r_acc;
    logic [1:0]  r_cnt;
    logic        r_done;
    logic [62:0] r_res;

    logic [16:0] bsel;
    logic [79:0] pp;
    logic [96:0] half;
    logic [96:0] lim;
    logic [96:0] rnd;
    logic [96:0] shf;
    logic [62:0] res;

    always_comb begin
        bsel = (r_cnt == 2'd1) ? r_b[16:0] : r_b[33:17];
        pp   = 80'(r_a) * 80'(bsel);
        half = r_sh ? (97'(1) << 31) : (97'(1) << 15);
        lim  = (97'(1) << 64) - half;
        rnd  = r_acc + half;
        shf  = r_sh ? (rnd >> 32) : (rnd >> 16);
        if (r_acc >= lim) begin
            res = UCAP;
        end else if (shf > 97'(UCAP)) begin
            res = UCAP;
        end else begin
            res = shf[62:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_cnt)
                2'd0: begin
                    if (i_req.start) begin
                        r_cnt <= 2'd1;
                    end
                end
                2'd1: r_cnt <= 2'd2;
                2'd2: r_cnt <= 2'd3;
                default: begin
                    r_cnt  <= 2'd0;
                    r_done <= 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_cnt)
            2'd0: begin
                if (i_req.start) begin
                    r_a  <= i_req.a;
                    r_b  <= i_req.b;
                    r_sh <= i_req.sh32;
                end
            end
            2'd1: r_acc <= 97'(pp);
            2'd2: r_acc <= r_acc + (97'(pp) << 17);
            default: r_res <= res;
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

endmodule

[hw/rtl/cdf_div.sv]
// cdf_div: shared restoring divider, one quotient bit per cycle, 50-bit
// numerator and divisor, quotient out. Uses cdf_pkg.
module cdf_div import cdf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic [49:0] r_n;
    logic [49:0] r_d;
    logic [50:0] r_rem;
    logic [49:0] r_q;
    logic [5:0]  r_cnt;
    logic        r_done;

    logic [50:0] t;
    logic        ge;

    always_comb begin
        t  = {r_rem[49:0], r_n[49]};
        ge = t >= {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (r_cnt == '0) begin
                if (i_req.start) begin
                    r_cnt <= 6'(DIV_STEPS);
                end
            end else begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cnt == '0) begin
            if (i_req.start) begin
                r_n   <= i_req.n;
                r_d   <= i_req.d;
                r_rem <= '0;
                r_q   <= '0;
            end
        end else begin
            r_n   <= {r_n[48:0], 1'b0};
            r_rem <= ge ? (t - {1'b0, r_d}) : t;
            r_q   <= {r_q[48:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_q;

endmodule

[hw/rtl/critically_damped_follower.sv]
// critically_damped_follower: top level, sequencer over one shared multiplier
// and one shared divider. Uses cdf_pkg, cdf_mul and cdf_div.
//
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_stall   i_in  (t_in)
//  out      output     o_out_valid / i_out_stall o_out (t_out)
//  cfg      input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// one request runs two 50-step divides on the divider and ten or eleven
// multiplies on the 63x17 multiplier, eleven when an angle needs wrapping, all
// in series between accepting the request and writing it back. The second
// divide is skipped when the exp term is zero.
// reset clears velocity and loads the register defaults.
// the result waits in an output register; the next request is taken meanwhile,
// and the last step holds only while that register is full and stalled.
module critically_damped_follower import cdf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [23:0] i_cfg_data
);
    t_state r_state, n_state;
    logic   r_issued;

    logic [23:0]        r_st;
    logic               r_ang;
    logic signed [31:0] r_vel;
    logic signed [31:0] r_cur;
    logic signed [31:0] r_tin;
    logic [15:0]        r_dt;
    logic signed [34:0] r_tgt;
    logic signed [63:0] r_delta;
    logic [31:0]        r_omega;
    logic [31:0]        r_x;
    logic [62:0]        r_x2;
    logic [62:0]        r_x3;
    logic [62:0]        r_den;
    logic [32:0]        r_ef;
    logic signed [63:0] r_s;
    logic signed [63:0] r_temp;
    logic signed [63:0] r_s2;
    logic signed [31:0] r_val;
    logic               r_ov;
    t_out               r_out;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;
    t_div_req div_req;
    t_div_rsp div_rsp;

    logic               accept;
    logic [23:0]        st_eff;
    logic signed [63:0] d_ang;
    logic               wrap_hi;
    logic               wrap_lo;
    logic               need_wrap;
    logic signed [63:0] ang_n;
    logic [34:0]        wprod;
    logic signed [63:0] wrem0;
    logic signed [63:0] rem_s;
    logic signed [63:0] dn;
    logic               den_big;
    logic signed [63:0] op_s;
    logic               neg;
    logic signed [63:0] s_mag;
    logic signed [63:0] sres;
    logic               wb_go;

    cdf_mul u_mul (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(mul_req), .o_rsp(mul_rsp));
    cdf_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    always_comb begin
        accept    = i_in_valid && !o_in_stall;
        st_eff    = (r_st == '0) ? 24'd1 : r_st;
        d_ang     = 64'(r_tin) - 64'(r_cur);
        wrap_hi   = d_ang > PI_Q;
        wrap_lo   = d_ang < -PI_Q;
        need_wrap = r_ang && (wrap_hi || wrap_lo);
        ang_n     = wrap_hi ? (d_ang + PI_Q) : (PI_Q - d_ang);
        // remainder by 2*pi from the reciprocal quotient estimate
        wprod     = 35'(mul_rsp.res[15:0]) * 35'(TWO_PI_Q);
        wrem0     = ang_n - signed'(64'(wprod));
        if (wrem0 < 0) begin
            rem_s = wrem0 + signed'(64'(TWO_PI_Q));
        end else begin
            rem_s = wrem0;
        end
        dn        = wrap_hi ? (rem_s - PI_Q) : (PI_Q - rem_s);
        den_big   = r_den > (63'(1) << 49);
        case (r_state)
            S_T1:    op_s = r_delta;
            S_T2:    op_s = r_s;
            S_T3:    op_s = r_temp;
            S_V:     op_s = r_s;
            S_VAL:   op_s = r_s2;
            default: op_s = '0;
        endcase
        neg   = op_s[63];
        s_mag = (mul_rsp.res > 63'(SLIM)) ? SLIM : signed'(64'(mul_rsp.res));
        sres  = neg ? -s_mag : s_mag;
        wb_go = !r_ov || !i_out_stall;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_OMEGA;
            S_OMEGA: if (div_rsp.done) n_state = S_ANGLE;
            S_ANGLE: if (!need_wrap || mul_rsp.done) n_state = S_X;
            S_X:     if (mul_rsp.done) n_state = S_X2;
            S_X2:    if (mul_rsp.done) n_state = S_X3;
            S_X3:    if (mul_rsp.done) n_state = S_C1;
            S_C1:    if (mul_rsp.done) n_state = S_C2;
            S_C2:    if (mul_rsp.done) n_state = S_EF;
            S_EF:    if (den_big || div_rsp.done) n_state = S_T1;
            S_T1:    if (mul_rsp.done) n_state = S_T2;
            S_T2:    if (mul_rsp.done) n_state = S_T3;
            S_T3:    if (mul_rsp.done) n_state = S_V;
            S_V:     if (mul_rsp.done) n_state = S_VAL;
            S_VAL:   if (mul_rsp.done) n_state = S_WB;
            S_WB:    if (wb_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // unit requests and handshake outputs
    always_comb begin
        o_in_stall    = r_state != S_IDLE;
        mul_req.start = 1'b0;
        mul_req.a     = 63'(unsigned'(neg ? -op_s : op_s));
        mul_req.b     = 34'(r_omega);
        mul_req.sh32  = 1'b0;
        div_req.start = 1'b0;
        div_req.n     = 50'(64'd1 << 33) + 50'(st_eff >> 1);
        div_req.d     = 50'(st_eff);
        case (r_state)
            S_OMEGA: div_req.start = !r_issued;
            S_ANGLE: begin
                mul_req.start = need_wrap && !r_issued;
                mul_req.a     = 63'(unsigned'(ang_n));
                mul_req.b     = RECIP_2PI;
                mul_req.sh32  = 1'b1;
            end
            S_X: begin
                mul_req.start = !r_issued;
                mul_req.a     = 63'(r_omega);
                mul_req.b     = 34'(r_dt);
            end
            S_X2: begin
                mul_req.start = !r_issued;
                mul_req.a     = 63'(r_x);
                mul_req.b     = 34'(r_x);
            end
            S_X3: begin
                mul_req.start = !r_issued;
                mul_req.a     = r_x2;
                mul_req.b     = 34'(r_x);
            end
            S_C1: begin
                mul_req.start = !r_issued;
                mul_req.a     = r_x2;
                mul_req.b     = C048;
            end
            S_C2: begin
                mul_req.start = !r_issued;
                mul_req.a     = r_x3;
                mul_req.b     = C0235;
            end
            S_EF: begin
                div_req.start = !den_big && !r_issued;
                div_req.n     = 50'(64'd1 << 48) + 50'(r_den >> 1);
                div_req.d     = 50'(r_den);
            end
            S_T1, S_T3: mul_req.start = !r_issued;
            S_T2: begin
                mul_req.start = !r_issued;
                mul_req.b     = 34'(r_dt);
            end
            S_V, S_VAL: begin
                mul_req.start = !r_issued;
                mul_req.b     = 34'(r_ef);
                mul_req.sh32  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
            r_st     <= ST_RESET;
            r_ang    <= 1'b0;
            r_vel    <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_issued <= (n_state != r_state) ? 1'b0
                      : (r_issued || mul_req.start || div_req.start);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SMOOTH_TIME: r_st  <= i_cfg_data;
                    CFG_ANGLE_MODE:  r_ang <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (r_state == S_V && mul_rsp.done) begin
                r_vel <= f_sat32(sres);
            end
            if (r_state == S_WB && wb_go) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cur <= i_in.current_value;
            r_tin <= i_in.target_value;
            r_dt  <= i_in.frame_time;
        end
        case (r_state)
            S_OMEGA: begin
                if (div_rsp.done) begin
                    r_omega <= (div_rsp.q > 50'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : div_rsp.q[31:0];
                end
            end
            S_ANGLE: begin
                if (!need_wrap) begin
                    r_tgt   <= 35'(r_tin);
                    r_delta <= 64'(r_cur) - 64'(r_tin);
                end else if (mul_rsp.done) begin
                    r_tgt   <= 35'(64'(r_cur) + dn);
                    r_delta <= -dn;
                end
            end
            S_X: begin
                if (mul_rsp.done) begin
                    r_x   <= mul_rsp.res[31:0];
                    r_den <= 63'd65536 + 63'(mul_rsp.res[31:0]);
                end
            end
            S_X2: if (mul_rsp.done) r_x2 <= mul_rsp.res;
            S_X3: if (mul_rsp.done) r_x3 <= mul_rsp.res;
            S_C1, S_C2: if (mul_rsp.done) r_den <= f_uadd(r_den, mul_rsp.res);
            S_EF: begin
                if (den_big) begin
                    r_ef <= '0;
                end else if (div_rsp.done) begin
                    r_ef <= div_rsp.q[32:0];
                end
            end
            S_T1: if (mul_rsp.done) r_s <= f_sclamp(64'(r_vel) + sres);
            S_T2: begin
                if (mul_rsp.done) begin
                    r_temp <= sres;
                    r_s2   <= f_sclamp(r_delta + sres);
                end
            end
            S_T3: if (mul_rsp.done) r_s <= f_sclamp(64'(r_vel) - sres);
            S_VAL: if (mul_rsp.done) r_val <= f_sat32(64'(r_tgt) + sres);
            S_WB: begin
                if (wb_go) begin
                    r_out.new_value    <= r_val;
                    r_out.new_velocity <= r_vel;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_in_stall)
        else $error("request accepted but block not busy");

    a_vel_only_at_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state == S_V && mul_rsp.done) |=> $stable(r_vel))
        else $error("velocity changed outside its update step");

    a_mul_done_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_rsp.done |-> (r_state != S_IDLE && r_state != S_WB && r_issued))
        else $error("multiplier finished with no operation pending");

endmodule
